@@ design/lph_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

   localparam int TableSlotsDefault = 1024;
   localparam int ValueBytesDefault = 8;

   localparam logic [31:0] FnvOffset = 32'd2166136261;
   localparam logic [31:0] FnvPrime  = 32'd16777619;
   localparam logic [3:0]  KeyBytesReset = 4'd8;

   typedef enum logic [1:0] {
      MODE_PUT = 2'd0,
      MODE_GET = 2'd1,
      MODE_DEL = 2'd2,
      MODE_ALT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY  = 2'd0,
      SLOT_FILLED = 2'd1,
      SLOT_TOMB   = 2'd2,
      SLOT_SPARE  = 2'd3
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_PROBE,
      ST_RESP
   } fsm_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] key;
      logic [63:0] new_value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] value_out;
      logic [9:0]  slot_index;
      logic        table_full;
      logic [10:0] entry_count;
   } rsp_type;

endpackage

@@ design/lph_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

@@ design/linear_probe_hash_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Put, get and delete of 64-bit keys in an open addressed table; the fourth mode is served as a get.
// ----------------------------------------------------------------------------
// After reset the block sweeps all TABLE_SLOTS entries to empty, one per
// cycle, and accepts no request during that pass. A request is then hashed
// with FNV-1a over the low key bytes, as many as the key width register
// gives, clamped to 1..8 (one byte per multiply). The hash is then reduced
// to a slot, directly when TABLE_SLOTS is a power of two, or by reciprocal
// reduction otherwise; the last reduction step issues the first table read,
// but a delete on an empty table goes straight to its result. Slots are then
// probed one at a time on the single table memory, and the result is posted
// once the output register is free. The block takes the next request in the
// cycle after that. Requests are taken one at a time; a finished result may
// wait in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_SLOTS = lph_pkg::TableSlotsDefault,
   parameter int VALUE_BYTES = lph_pkg::ValueBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lph_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lph_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_data
);

   import lph_pkg::*;

   localparam int  AW      = $clog2(TABLE_SLOTS);
   localparam int  CW      = $clog2(TABLE_SLOTS + 1);
   localparam int  VW      = 8 * VALUE_BYTES;
   localparam int  EW      = 2 + 64 + VW;
   localparam bit  IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);
   localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
   localparam logic [AW+1:0] SLOTS_W = (AW+2)'(TABLE_SLOTS);

   fsm_type        state_ff, state_in;
   req_type        req_ff, req_in;
   rsp_type        res_ff, res_in;
   rsp_type        rsp_payload_ff, rsp_payload_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    h_ff, h_in;
   logic [2:0]     hcnt_ff, hcnt_in;
   logic [1:0]     mcnt_ff, mcnt_in;
   logic [31:0]    quo_ff, quo_in;
   logic [AW+1:0]  rem_ff, rem_in;
   logic [AW-1:0]  home_ff, home_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  x_ff, x_in;
   logic [AW-1:0]  tomb_ff, tomb_in;
   logic           have_tomb_ff, have_tomb_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [3:0]     kb_ff;

   logic           ram_we, ram_re;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [EW-1:0]  ram_wdata, ram_rdata;

   logic [3:0]     kb_eff;
   logic [63:0]    kmask;
   logic [63:0]    quo_prod;
   logic [AW+1:0]  rem_sub;
   logic [AW-1:0]  home_done, idx_next;
   logic [1:0]     rd_st;
   logic [63:0]    rd_key;
   logic [VW-1:0]  rd_val, nval;
   logic           is_put, is_del;

   lph_ram #(
      .WIDTH(EW),
      .DEPTH(TABLE_SLOTS)
   ) u_slots (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_en      (ram_re),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   assign csr_ready   = 1'b1;
   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      if (kb_ff == 4'd0) begin
         kb_eff = 4'd1;
      end else if (kb_ff > 4'd8) begin
         kb_eff = 4'd8;
      end else begin
         kb_eff = kb_ff;
      end
      for (int i = 0; i < 8; i++) begin
         kmask[i*8 +: 8] = (4'(i) < kb_eff) ? 8'hFF : 8'h00;
      end
   end

   assign rd_st    = ram_rdata[EW-1 -: 2];
   assign rd_key   = ram_rdata[VW +: 64];
   assign rd_val   = ram_rdata[VW-1:0];
   assign nval     = req_ff.new_value[VW-1:0];
   assign is_put   = req_ff.mode == MODE_PUT;
   assign is_del   = req_ff.mode == MODE_DEL;
   assign idx_next = (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
   assign quo_prod = {32'd0, h_ff} * {32'd0, RECIP};
   assign rem_sub  = h_ff[AW+1:0] - quo_ff[AW+1:0] * SLOTS_W;

   always_comb begin
      if (IS_POW2) begin
         home_done = h_ff[AW-1:0];
      end else if (rem_ff >= SLOTS_W) begin
         home_done = AW'(rem_ff - SLOTS_W);
      end else begin
         home_done = rem_ff[AW-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      h_in           = h_ff;
      hcnt_in        = hcnt_ff;
      mcnt_in        = mcnt_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      home_in        = home_ff;
      idx_in         = idx_ff;
      x_in           = x_ff;
      tomb_in        = tomb_ff;
      have_tomb_in   = have_tomb_ff;
      count_in       = count_ff;
      clr_in         = clr_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = '0;
      ram_re         = 1'b0;
      ram_raddr      = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = {SLOT_EMPTY, 64'd0, VW'(0)};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               h_in     = FnvOffset;
               hcnt_in  = '0;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            h_in    = (h_ff ^ {24'd0, req_ff.key[hcnt_ff*8 +: 8]}) * FnvPrime;
            hcnt_in = hcnt_ff + 1'b1;
            mcnt_in = '0;
            rem_in  = '0;
            if ({1'b0, hcnt_ff} == kb_eff - 4'd1) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // estimate the quotient by reciprocal, subtract, then correct once
            quo_in  = quo_prod[63:32];
            rem_in  = rem_sub;
            mcnt_in = mcnt_ff + 1'b1;
            if (IS_POW2 || mcnt_ff == 2'd2) begin
               home_in      = home_done;
               idx_in       = home_done;
               x_in         = '0;
               have_tomb_in = 1'b0;
               res_in       = '0;
               res_in.slot_index = 10'(home_done);
               if (is_del && count_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = home_done;
                  state_in  = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            res_in = '0;
            res_in.slot_index = 10'(idx_ff);
            if (rd_st == SLOT_EMPTY) begin
               if (is_put) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff;
                  ram_wdata = {SLOT_FILLED, req_ff.key & kmask, nval};
                  count_in  = count_ff + 1'b1;
               end
               state_in = ST_RESP;
            end else if (rd_st == SLOT_FILLED && ((rd_key ^ req_ff.key) & kmask) == 64'd0) begin
               res_in.found = 1'b1;
               if (is_put) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff;
                  ram_wdata = {SLOT_FILLED, rd_key, nval};
               end else if (is_del) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff;
                  ram_wdata = {SLOT_TOMB, rd_key, rd_val};
                  count_in  = count_ff - 1'b1;
                  res_in.value_out = 64'(rd_val);
               end else begin
                  res_in.value_out = 64'(rd_val);
               end
               state_in = ST_RESP;
            end else begin
               if (rd_st != SLOT_FILLED && !have_tomb_ff) begin
                  have_tomb_in = 1'b1;
                  tomb_in      = idx_ff;
               end
               if (x_ff == LAST) begin
                  // wrapped all the way: end at first tombstone or home
                  if (have_tomb_in) begin
                     res_in.slot_index = 10'(tomb_in);
                     if (is_put) begin
                        ram_we    = 1'b1;
                        ram_waddr = tomb_in;
                        ram_wdata = {SLOT_FILLED, req_ff.key & kmask, nval};
                        count_in  = count_ff + 1'b1;
                     end
                  end else begin
                     res_in.slot_index = 10'(home_ff);
                     res_in.table_full = is_put;
                  end
                  state_in = ST_RESP;
               end else begin
                  idx_in    = idx_next;
                  x_in      = x_ff + 1'b1;
                  ram_re    = 1'b1;
                  ram_raddr = idx_next;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in             = res_ff;
               rsp_payload_in.entry_count = 11'(count_ff);
               rsp_valid_in               = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         clr_ff       <= '0;
         kb_ff        <= KeyBytesReset;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         if (csr_valid && csr_ready) begin
            kb_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
      h_ff           <= h_in;
      hcnt_ff        <= hcnt_in;
      mcnt_ff        <= mcnt_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      home_ff        <= home_in;
      idx_ff         <= idx_in;
      x_ff           <= x_in;
      tomb_ff        <= tomb_in;
      have_tomb_ff   <= have_tomb_in;
   end

endmodule

@@ dv/linear_probe_hash_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear probing hash table: a directed table of
// put, get and delete beats, then random traffic over small key sets under
// several key widths, each result checked against a behavioral table model.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
   import lph_pkg::*;

   localparam int Slots = 1024;
   localparam int WatchLimit = 20000;
   localparam int DrainCycles = 2200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [3:0] csr_data = '0;

   linear_probe_hash_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // table model
   slot_type    tbl_state [Slots];
   logic [63:0] tbl_key [Slots];
   logic [63:0] tbl_val [Slots];
   int unsigned tbl_count;
   logic [3:0]  key_width;

   rsp_type     rsp_expected [$];
   int          err_count = 0;
   int          rsp_seen = 0;
   int          watch = 0;
   int          puts = 0, gets = 0, dels = 0, fulls = 0;
   logic        stall_mode = 1'b0;
   int          stall_left = 0;
   int unsigned gap_odds = 0;
   logic [3:0]  key_width_list [] = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd7, 4'd8};

   function automatic int unsigned eff_width();
      if (key_width == 0) return 1;
      if (key_width > 8) return 8;
      return key_width;
   endfunction

   function automatic logic [63:0] key_mask(int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (n * 8)) - 64'd1;
   endfunction

   function automatic int unsigned home_slot(logic [63:0] k, int unsigned n);
      logic [31:0] h;
      h = FnvOffset;
      for (int i = 0; i < n; i++) begin
         h = h ^ {24'd0, k[i*8 +: 8]};
         h = h * FnvPrime;
      end
      return h % Slots;
   endfunction

   function automatic rsp_type table_apply(req_type r);
      rsp_type     o;
      int unsigned n, home, s, idx, tomb;
      logic [63:0] km;
      logic        hit, empty_stop, have_tomb, done;
      n = eff_width();
      km = key_mask(n);
      home = home_slot(r.key, n);
      o = '0;
      hit = 0; empty_stop = 0; have_tomb = 0; done = 0; tomb = 0; s = home;
      if (r.mode == MODE_DEL && tbl_count == 0) begin
         s = home;
      end else begin
         for (int x = 0; x < Slots && !done; x++) begin
            idx = (home + x) % Slots;
            if (tbl_state[idx] == SLOT_EMPTY) begin
               empty_stop = 1; s = idx; done = 1;
            end else if (tbl_state[idx] == SLOT_FILLED) begin
               if (((tbl_key[idx] ^ r.key) & km) == 0) begin
                  hit = 1; s = idx; done = 1;
               end
            end else if (!have_tomb) begin
               have_tomb = 1; tomb = idx;
            end
         end
         if (!done) s = have_tomb ? tomb : home;
         o.found = hit;
         if (r.mode == MODE_PUT) begin
            if (hit) begin
               tbl_val[s] = r.new_value;
            end else if (empty_stop || tbl_state[s] == SLOT_TOMB) begin
               tbl_state[s] = SLOT_FILLED;
               tbl_key[s] = r.key & km;
               tbl_val[s] = r.new_value;
               tbl_count++;
            end else begin
               o.table_full = 1; s = home;
            end
         end else if (r.mode == MODE_DEL) begin
            if (hit) begin
               o.value_out = tbl_val[s];
               tbl_state[s] = SLOT_TOMB;
               tbl_count--;
            end
         end else if (hit) begin
            o.value_out = tbl_val[s];
         end
      end
      o.slot_index = s[9:0];
      o.entry_count = tbl_count[10:0];
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at result %0d: %s", rsp_seen, msg);
      err_count++;
   endtask

   // response checker and stall generator
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            watch <= 0;
         else
            watch <= watch + 1;
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (rsp_expected.size() == 0) begin
               report_mismatch("result beat with nothing outstanding");
            end else begin
               e = rsp_expected.pop_front();
               if (rsp_payload.found !== e.found)
                  report_mismatch($sformatf("found got %h expected %h",
                                            rsp_payload.found, e.found));
               if (rsp_payload.value_out !== e.value_out)
                  report_mismatch($sformatf("value_out got %h expected %h",
                                            rsp_payload.value_out, e.value_out));
               if (rsp_payload.slot_index !== e.slot_index)
                  report_mismatch($sformatf("slot_index got %h expected %h",
                                            rsp_payload.slot_index, e.slot_index));
               if (rsp_payload.table_full !== e.table_full)
                  report_mismatch($sformatf("table_full got %h expected %h",
                                            rsp_payload.table_full, e.table_full));
               if (rsp_payload.entry_count !== e.entry_count)
                  report_mismatch($sformatf("entry_count got %h expected %h",
                                            rsp_payload.entry_count, e.entry_count));
            end
         end
         // mostly short stalls, now and then a long one
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (stall_mode && ($urandom_range(0, 99) < 30)) begin
            rsp_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : 0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (watch >= WatchLimit) begin
         $display("watchdog expired with %0d results pending", rsp_expected.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      repeat (n) @(posedge clock);
   endtask

   // drive one request beat; expectation is queued at acceptance
   task automatic send_req(mode_type m, logic [63:0] k, logic [63:0] v);
      req_type r;
      rsp_type o;
      r.mode = m; r.key = k; r.new_value = v;
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      o = table_apply(r);
      rsp_expected.push_back(o);
      if (o.table_full) fulls++;
      case (m)
         MODE_PUT: puts++;
         MODE_DEL: dels++;
         default:  gets++;
      endcase
      if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
         req_valid <= 1'b0;
         idle_gap();
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_width(logic [3:0] w);
      csr_valid <= 1'b1;
      csr_data <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      key_width = w;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   typedef struct {
      mode_type    m;
      logic [63:0] k;
      logic [63:0] v;
      logic        chk;
      rsp_type     want;
   } vec_type;

   vec_type vectors [] = '{
      '{MODE_DEL, 64'h0, 64'h0, 1'b0, '0},
      '{MODE_GET, 64'h0, 64'h0, 1'b0, '0},
      '{MODE_PUT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{MODE_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, '0},
      '{MODE_GET, 64'h0, 64'h0, 1'b0, '0},
      '{MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, '0},
      '{MODE_PUT, 64'h0, 64'h1234_5678_9ABC_DEF0, 1'b0, '0},
      '{MODE_ALT, 64'h0, 64'h0, 1'b0, '0},
      '{MODE_DEL, 64'h0, 64'h0, 1'b0, '0},
      '{MODE_DEL, 64'h0, 64'h0, 1'b0, '0},
      '{MODE_PUT, 64'h0, 64'h5555_AAAA_5555_AAAA, 1'b0, '0},
      '{MODE_DEL, 64'h1, 64'h0, 1'b0, '0},
      '{MODE_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, '0},
      '{MODE_DEL, 64'h0, 64'h0, 1'b0, '0},
      '{MODE_GET, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0}
   };

   // two-byte keys fill every slot so the full and wrap cases are reached
   task automatic fill_table();
      for (int i = 0; i < Slots; i++)
         send_req(MODE_PUT, ({$urandom, $urandom} & ~64'hFFFF) | 64'(i),
                  {$urandom, $urandom});
      send_req(MODE_PUT, 64'h77_0000_F00D, 64'h0);
   endtask

   task automatic random_phase(int n, int unsigned pool);
      logic [63:0] keys [];
      int          p;
      keys = new[pool];
      foreach (keys[i]) keys[i] = {$urandom, $urandom};
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         if (p < 40)
            send_req(MODE_PUT, keys[$urandom_range(0, pool - 1)], {$urandom, $urandom});
         else if (p < 65)
            send_req(MODE_GET, keys[$urandom_range(0, pool - 1)], {$urandom, $urandom});
         else if (p < 88)
            send_req(MODE_DEL, keys[$urandom_range(0, pool - 1)], {$urandom, $urandom});
         else if (p < 94)
            send_req(MODE_ALT, keys[$urandom_range(0, pool - 1)], {$urandom, $urandom});
         else
            send_req(mode_type'($urandom_range(0, 3)), {$urandom, $urandom}, {$urandom, $urandom});
      end
   endtask

   initial begin
      foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
      tbl_count = 0;
      key_width = KeyBytesReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty-table delete and miss have obvious results
      vectors[0].chk = 1; vectors[0].want = '0;
      vectors[0].want.slot_index = 10'(home_slot(64'h0, 8));
      vectors[1].chk = 1; vectors[1].want = '0;
      vectors[1].want.slot_index = 10'(home_slot(64'h0, 8));
      foreach (vectors[i]) begin
         send_req(vectors[i].m, vectors[i].k, vectors[i].v);
         if (vectors[i].chk && rsp_expected[$] !== vectors[i].want)
            report_mismatch($sformatf("directed row %0d disagrees with table model", i));
      end
      drain();

      write_width(4'd2);
      gap_odds = 20; stall_mode = 1;
      fill_table();
      random_phase(100, 300);
      drain();

      write_width(4'd0);
      random_phase(150, 40);
      drain();

      write_width(4'd15);
      gap_odds = 0; stall_mode = 0;
      random_phase(150, 60);
      drain();

      foreach (key_width_list[i]) begin
         write_width(key_width_list[i]);
         gap_odds = (i % 2) ? 35 : 10; stall_mode = (i % 3 != 0);
         random_phase(70, 80);
         drain();
      end

      $display("covered %0d puts, %0d gets, %0d deletes across key widths 0 to 15",
               puts, gets, dels);
      $display("%0d refused puts on a full table, %0d results checked, %0d mismatches",
               fulls, rsp_seen, err_count);
      if (err_count == 0 && rsp_expected.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
